/* src/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants for the rotation matrix to Euler angle block.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int unsigned ITERS = 40;
  localparam int unsigned CW    = 44;   // CORDIC datapath width
  localparam int unsigned ZW    = 45;   // Q40 angle accumulator width

  localparam logic signed [ZW-1:0] PI_Q40 = 45'sd3454217652358;

  typedef logic signed [CW-1:0] cdata_t;
  typedef logic signed [ZW-1:0] zang_t;

  typedef struct packed {
    cdata_t x;
    cdata_t y;
    zang_t  z;
  } cvec_t;

  typedef struct packed {
    logic order;
    logic lock;
    logic [1:0] neg;   // negate results of the two atan2 units
    logic zero_a;      // first atan2 result forced to zero
    logic zero_b;
  } side_t;

  function automatic zang_t atan_tab(input int unsigned i);
    zang_t t;
    unique case (i)
      0:  t = 45'sd863554413089;  1:  t = 45'sd509785937287;
      2:  t = 45'sd269356888665;  3:  t = 45'sd136729762476;
      4:  t = 45'sd68630207382;   5:  t = 45'sd34348560106;
      6:  t = 45'sd17178471287;   7:  t = 45'sd8589759836;
      8:  t = 45'sd4294945451;    9:  t = 45'sd2147480917;
      10: t = 45'sd1073741483;    11: t = 45'sd536870869;
      12: t = 45'sd268435451;     13: t = 45'sd134217727;
      14: t = 45'sd67108864;      15: t = 45'sd33554432;
      16: t = 45'sd16777216;      17: t = 45'sd8388608;
      18: t = 45'sd4194304;       19: t = 45'sd2097152;
      20: t = 45'sd1048576;       21: t = 45'sd524288;
      22: t = 45'sd262144;        23: t = 45'sd131072;
      24: t = 45'sd65536;         25: t = 45'sd32768;
      26: t = 45'sd16384;         27: t = 45'sd8192;
      28: t = 45'sd4096;          29: t = 45'sd2048;
      30: t = 45'sd1024;          31: t = 45'sd512;
      32: t = 45'sd256;           33: t = 45'sd128;
      34: t = 45'sd64;            35: t = 45'sd32;
      36: t = 45'sd16;            37: t = 45'sd8;
      38: t = 45'sd4;             default: t = 45'sd2;
    endcase
    return t;
  endfunction

endpackage

/* src/rme_isqrt.sv */
// ----------------------------------------------------------------------------
// rme_isqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rme_isqrt import rme_pkg::*; #(
  parameter int unsigned IW = 62
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   din,
  output logic [IW/2-1:0] dout
);
  localparam int unsigned NS = IW / 2;
  localparam int unsigned RW = NS + 2;

  logic [IW-1:0] v_r [NS+1];
  logic [RW-1:0] rem_r [NS+1];
  logic [NS-1:0] q_r [NS+1];

  always_comb begin
    v_r[0]   = din;
    rem_r[0] = '0;
    q_r[0]   = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [RW-1:0] trial;
    logic [RW-1:0] rsh;
    logic [RW-1:0] rem_nxt;
    logic [NS-1:0] q_nxt;
    always_comb begin
      rsh   = {rem_r[s][RW-3:0], v_r[s][IW-1 -: 2]};
      trial = {q_r[s], 2'b01};
      if (rsh >= trial) begin
        rem_nxt = rsh - trial;
        q_nxt   = {q_r[s][NS-2:0], 1'b1};
      end else begin
        rem_nxt = rsh;
        q_nxt   = {q_r[s][NS-2:0], 1'b0};
      end
    end
    logic [IW-1:0] v_nr;
    logic [RW-1:0] rem_nr;
    logic [NS-1:0] q_nr;
    always_ff @(posedge clk) begin
      if (en) begin
        v_nr   <= {v_r[s][IW-3:0], 2'b00};
        rem_nr <= rem_nxt;
        q_nr   <= q_nxt;
      end
    end
    assign v_r[s+1]   = v_nr;
    assign rem_r[s+1] = rem_nr;
    assign q_r[s+1]   = q_nr;
  end

  assign dout = q_r[NS];
endmodule

/* src/rme_cordic.sv */
// ----------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC atan2, Q40 angle out, one micro-rotation a stage.
// ----------------------------------------------------------------------------
module rme_cordic import rme_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  cdata_t       y_in,
  input  cdata_t       x_in,
  output zang_t        ang
);
  localparam int unsigned NS = ITERS + 2;

  cvec_t st_r [NS];
  logic  zero_r [NS];

  // stage 0: quadrant fold
  cvec_t p0;
  logic  z0;
  always_comb begin
    p0.x = x_in; p0.y = y_in; p0.z = '0;
    z0   = (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      p0.x = -x_in; p0.y = -y_in;
      p0.z = (y_in >= 0) ? PI_Q40 : -PI_Q40;
    end
  end
  cvec_t p0_r;
  logic  z0_r;
  always_ff @(posedge clk) if (en) begin
    p0_r <= p0; z0_r <= z0;
  end
  assign st_r[0] = p0_r; assign zero_r[0] = z0_r;

  // stage 1: normalise magnitude to at least 2^30
  cvec_t p1;
  always_comb begin
    logic [CW-1:0] ay;
    logic [CW-1:0] m;
    int unsigned sh;
    ay = st_r[0].y[CW-1] ? -st_r[0].y : st_r[0].y;
    m  = st_r[0].x | ay;
    sh = 0;
    for (int k = 0; k <= 30; k++) if (m[k] && m < (CW'(1) << 30)) sh = 30 - k;
    if (m >= (CW'(1) << 30)) sh = 0;
    if (m == '0) sh = 0;
    p1.x = st_r[0].x <<< sh;
    p1.y = st_r[0].y <<< sh;
    p1.z = st_r[0].z;
  end
  cvec_t p1_r;
  logic  z1_r;
  always_ff @(posedge clk) if (en) begin
    p1_r <= p1; z1_r <= zero_r[0];
  end
  assign st_r[1] = p1_r; assign zero_r[1] = z1_r;

  for (genvar i = 0; i < ITERS; i++) begin : g_it
    cvec_t n;
    always_comb begin
      n = st_r[i+1];
      if (!st_r[i+1].y[CW-1] && st_r[i+1].y != '0) begin
        n.x = st_r[i+1].x + (st_r[i+1].y >>> i);
        n.y = st_r[i+1].y - (st_r[i+1].x >>> i);
        n.z = st_r[i+1].z + atan_tab(i);
      end else if (st_r[i+1].y[CW-1]) begin
        n.x = st_r[i+1].x - (st_r[i+1].y >>> i);
        n.y = st_r[i+1].y + (st_r[i+1].x >>> i);
        n.z = st_r[i+1].z - atan_tab(i);
      end
    end
    cvec_t n_r;
    logic  zz_r;
    always_ff @(posedge clk) if (en) begin
      n_r <= n; zz_r <= zero_r[i+1];
    end
    assign st_r[i+2] = n_r; assign zero_r[i+2] = zz_r;
  end

  assign ang = zero_r[NS-1] ? '0 : st_r[NS-1].z;
endmodule

/* src/rotation_matrix_to_euler_top.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top
// Rotation matrix to Euler angles (X-Y-Z / Z-X-Y), fully pipelined.
// ----------------------------------------------------------------------------
// channel  | dir | contents
// in_      | in  | eight Q1.16 matrix entries
// out_     | out | three Q2.16 angles, gimbal-lock flag
// cfg_     | in  | angle order bit
//
// One beat per cycle while the output is taken; stages: an input register, a
// 31-stage square root feeding a 42-stage CORDIC, and the output register.
// The whole pipe advances only when the output register is free or taken.
// Reset clears valid bits and the order register only.
module rotation_matrix_to_euler_top import rme_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // r00 r01 r02 r10 r11 r12 r20 r22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // angle_x angle_y angle_z gimbal_lock, pad
  input  logic         cfg_we,
  input  logic         cfg_wdata
);
  localparam int unsigned SQ = 31;
  localparam int unsigned CD = ITERS + 2;
  localparam int unsigned LAT = 1 + SQ + CD;

  logic order_r;
  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= 1'b0;
    else if (cfg_we) order_r <= cfg_wdata;
  end

  logic en;
  logic [LAT-1:0] vld_r;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0; out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // clamp
  logic signed [17:0] e [8];
  for (genvar k = 0; k < 8; k++) begin : g_cl
    logic signed [17:0] raw;
    assign raw = in_tdata[18*k +: 18];
    assign e[k] = (raw > 18'sd65536) ? 18'sd65536 :
                  (raw < -18'sd65536) ? -18'sd65536 : raw;
  end

  // stage A: pick operands, compute 1-k^2
  logic signed [17:0] k_a;
  logic signed [17:0] ay_a, ax_a, by_a, bx_a;
  side_t sd_a;
  logic [33:0] rem_a;
  always_comb begin
    logic [35:0] k2;
    k_a = order_r ? e[5] : e[2];
    k2  = 36'($signed(k_a) * $signed(k_a));
    rem_a = 34'((36'd1 << 32) - k2);
    sd_a.order = order_r;
    sd_a.zero_a = 1'b0; sd_a.zero_b = 1'b0;
    if (!order_r) begin
      sd_a.lock = (rem_a == '0);
      sd_a.neg  = 2'b11;
      if (!sd_a.lock) begin
        ay_a = -e[5]; ax_a = e[7]; by_a = -e[1]; bx_a = e[0];
      end else begin
        ay_a = '0; ax_a = '0; by_a = e[3]; bx_a = e[4]; sd_a.zero_a = 1'b1;
      end
    end else begin
      sd_a.lock = (58'(rem_a) * 58'd4000000) <= (58'd1 << 32);
      sd_a.neg  = 2'b00;
      if (!sd_a.lock) begin
        ay_a = -e[2]; ax_a = e[7]; by_a = -e[3]; bx_a = e[4];
      end else begin
        ay_a = e[6]; ax_a = e[0]; by_a = '0; bx_a = '0; sd_a.zero_b = 1'b1;
      end
    end
  end

  logic signed [17:0] k_r;
  logic signed [17:0] ay_r, ax_r, by_r, bx_r;
  side_t sd_r;
  logic [33:0] rem_r;
  always_ff @(posedge clk) if (en) begin
    k_r <= k_a; ay_r <= ay_a; ax_r <= ax_a; by_r <= by_a; bx_r <= bx_a;
    sd_r <= sd_a; rem_r <= rem_a;
  end

  // delay lines across square root
  logic signed [17:0] kd [SQ+1];
  logic signed [17:0] ayd [SQ+1], axd [SQ+1], byd [SQ+1], bxd [SQ+1];
  side_t sdd [SQ+1];
  assign kd[0] = k_r; assign ayd[0] = ay_r; assign axd[0] = ax_r;
  assign byd[0] = by_r; assign bxd[0] = bx_r; assign sdd[0] = sd_r;
  for (genvar s = 0; s < SQ; s++) begin : g_d
    logic signed [17:0] a0, a1, a2, a3, a4;
    side_t a5;
    always_ff @(posedge clk) if (en) begin
      a0 <= kd[s]; a1 <= ayd[s]; a2 <= axd[s]; a3 <= byd[s]; a4 <= bxd[s];
      a5 <= sdd[s];
    end
    assign kd[s+1] = a0; assign ayd[s+1] = a1; assign axd[s+1] = a2;
    assign byd[s+1] = a3; assign bxd[s+1] = a4; assign sdd[s+1] = a5;
  end

  logic [61:0] sq_in;
  logic [30:0] c_q;
  assign sq_in = {rem_r[33:0], 28'd0};
  rme_isqrt #(.IW(62)) u_sqrt (.clk(clk), .en(en), .din(sq_in), .dout(c_q));

  // three CORDIC units: asin, first atan2, second atan2
  zang_t ang_s, ang_a, ang_b;
  rme_cordic u_cs (.clk(clk), .en(en),
    .y_in(CW'($signed(kd[SQ]) * 32'sd16384)), .x_in(CW'({1'b0, c_q})), .ang(ang_s));
  rme_cordic u_ca (.clk(clk), .en(en),
    .y_in(CW'(ayd[SQ])), .x_in(CW'(axd[SQ])), .ang(ang_a));
  rme_cordic u_cb (.clk(clk), .en(en),
    .y_in(CW'(byd[SQ])), .x_in(CW'(bxd[SQ])), .ang(ang_b));

  side_t sdc [CD+1];
  assign sdc[0] = sdd[SQ];
  for (genvar s = 0; s < CD; s++) begin : g_sc
    side_t t;
    always_ff @(posedge clk) if (en) t <= sdc[s];
    assign sdc[s+1] = t;
  end
  side_t sd_o;
  assign sd_o = sdc[CD];

  function automatic logic [18:0] rnd(input zang_t a);
    zang_t t;
    t = a + (ZW'(1) << 23);
    return t[42:24];
  endfunction

  logic [18:0] rx, ry, rz;
  always_comb begin
    zang_t s, a, b;
    s = ang_s;
    a = sd_o.zero_a ? '0 : (sd_o.neg[0] ? -ang_a : ang_a);
    b = sd_o.zero_b ? '0 : (sd_o.neg[1] ? -ang_b : ang_b);
    if (!sd_o.order) begin
      rx = rnd(a); ry = rnd(-s); rz = rnd(b);
    end else begin
      rx = rnd(s); ry = rnd(a); rz = rnd(b);
    end
  end

  logic [63:0] odata_r;
  always_ff @(posedge clk) if (en) odata_r <= {6'd0, sd_o.lock, rz, ry, rx};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata_r;
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Rotation matrix to Euler angles: a directed table of matrices (identity,
// gimbal lock, clamped entries, zero and negative-axis atan2 cases) in both
// angle orders, then random rotations, locked rotations and raw noise. Each beat is
// checked field by field against typed angles or a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam longint ONE = 65536;

  typedef struct packed {
    logic [18:0] ax;
    logic [18:0] ay;
    logic [18:0] az;
    logic        lock;
  } euler_t;

  typedef struct {
    logic              order;
    logic [7:0][17:0]  m;
    logic              typed;
    euler_t            res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;

  logic         typed_nxt = 1'b0;
  euler_t       typed_res = '0;
  logic         order_cur = 1'b0;
  logic         quiet = 1'b0;
  int           fails = 0;

  longint       atan_lut[40];
  longint       pi_q40;
  euler_t       angles_q[$];
  row_t         rows[$];

  rotation_matrix_to_euler_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint atan_inv_q60(longint unsigned n);
    longint unsigned term;
    longint sum;
    longint unsigned k;
    term = (64'd1 << 60) / n;
    sum = 0;
    k = 0;
    while (term != 0) begin
      if (k[0]) sum = sum - longint'(term / (2 * k + 1));
      else sum = sum + longint'(term / (2 * k + 1));
      term = term / n / n;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned sqrt_u64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint base, z, nx, ny;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      base = (y >= 0) ? pi_q40 : -pi_q40;
      x = -x;
      y = -y;
    end
    while (x < (64'sd1 <<< 30) && (y < 0 ? -y : y) < (64'sd1 <<< 30)) begin
      x *= 2;
      y *= 2;
    end
    for (int i = 0; i < 40; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
      end else if (y < 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
      end else begin
        break;
      end
      x = nx;
      y = ny;
    end
    return base + z;
  endfunction

  function automatic longint cordic_asin(longint k);
    longint unsigned c;
    c = sqrt_u64(longint'(ONE * ONE - k * k) << 28);
    return cordic_atan2(k * 16384, longint'(c));
  endfunction

  function automatic longint clamp_entry(logic [17:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return v;
  endfunction

  function automatic logic [18:0] round_q16(longint a);
    longint r;
    r = (a + (64'sd1 <<< 23)) >>> 24;
    return r[18:0];
  endfunction

  function automatic euler_t predict_angles(logic [143:0] d, logic order);
    longint r00, r01, r02, r10, r11, r12, r20, r22, ax, ay, az;
    longint unsigned rem;
    euler_t e;
    r00 = clamp_entry(d[17:0]);    r01 = clamp_entry(d[35:18]);
    r02 = clamp_entry(d[53:36]);   r10 = clamp_entry(d[71:54]);
    r11 = clamp_entry(d[89:72]);   r12 = clamp_entry(d[107:90]);
    r20 = clamp_entry(d[125:108]); r22 = clamp_entry(d[143:126]);
    if (!order) begin
      ay = -cordic_asin(r02);
      e.lock = (r02 * r02 == ONE * ONE);
      if (!e.lock) begin
        ax = -cordic_atan2(-r12, r22);
        az = -cordic_atan2(-r01, r00);
      end else begin
        ax = 0;
        az = -cordic_atan2(r10, r11);
      end
    end else begin
      rem = longint'(ONE * ONE - r12 * r12);
      ax = cordic_asin(r12);
      e.lock = (rem * 4000000 <= (64'd1 << 32));
      if (!e.lock) begin
        ay = cordic_atan2(-r02, r22);
        az = cordic_atan2(-r10, r11);
      end else begin
        ay = cordic_atan2(r20, r00);
        az = 0;
      end
    end
    e.ax = round_q16(ax);
    e.ay = round_q16(ay);
    e.az = round_q16(az);
    return e;
  endfunction

  // accepted input beats
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      angles_q.push_back(typed_nxt ? typed_res : predict_angles(in_tdata, order_cur));
  end

  // output beats
  always @(posedge clk) begin
    euler_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[57:0];
      got = '{ax: out_tdata[18:0], ay: out_tdata[37:19], az: out_tdata[56:38],
              lock: out_tdata[57]};
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_tdata);
        fails++;
      end else begin
        want = angles_q.pop_front();
        if (got.ax !== want.ax) begin
          $display("%0t: angle_x expected %h actual %h", $time, want.ax, got.ax);
          fails++;
        end
        if (got.ay !== want.ay) begin
          $display("%0t: angle_y expected %h actual %h", $time, want.ay, got.ay);
          fails++;
        end
        if (got.az !== want.az) begin
          $display("%0t: angle_z expected %h actual %h", $time, want.az, got.az);
          fails++;
        end
        if (got.lock !== want.lock) begin
          $display("%0t: gimbal_lock expected %b actual %b", $time, want.lock, got.lock);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 21);
  end

  task automatic send_matrix(logic [143:0] d, logic typed, euler_t res);
    while (!quiet && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    typed_nxt <= typed;
    typed_res <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_and_set(logic order);
    in_tvalid <= 1'b0;
    typed_nxt <= 1'b0;
    @(posedge clk);
    while (angles_q.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= order;
    order_cur <= order;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_row(logic order, int a0, int a1, int a2, int a3, int a4, int a5,
                         int a6, int a7, logic typed, int ex, int ey, int ez, logic el);
    row_t r;
    r.order = order;
    r.m = {a7[17:0], a6[17:0], a5[17:0], a4[17:0], a3[17:0], a2[17:0], a1[17:0], a0[17:0]};
    r.typed = typed;
    r.res = '{ax: ex[18:0], ay: ey[18:0], az: ez[18:0], lock: el};
    rows.push_back(r);
  endtask

  function automatic logic [17:0] q16(real v);
    return 18'(int'($rtoi(v * 65536.0 + (v >= 0 ? 0.5 : -0.5))));
  endfunction

  function automatic logic [143:0] rand_rotation();
    real x, y, z, sx, cx, sy, cy, sz, cz;
    x = ($urandom_range(20000) / 10000.0 - 1.0) * 3.14159;
    y = ($urandom_range(20000) / 10000.0 - 1.0) * 1.5707;
    z = ($urandom_range(20000) / 10000.0 - 1.0) * 3.14159;
    sx = $sin(x); cx = $cos(x); sy = $sin(y); cy = $cos(y); sz = $sin(z); cz = $cos(z);
    return {q16(cy * cx), q16(-sy), q16(sz * sy * cx - cz * sx),
            q16(sz * sy * sx + cz * cx), q16(sz * cy),
            q16(cz * sy * cx + sz * sx), q16(cz * sy * sx - sz * cx), q16(cz * cy)};
  endfunction

  initial begin
    logic [143:0] d;
    logic [17:0]  s;
    int           pick;
    for (int i = 0; i < 40; i++)
      atan_lut[i] = (i == 0) ?
        ((atan_inv_q60(2) + atan_inv_q60(3) + (64'sd1 <<< 19)) >>> 20) :
        ((atan_inv_q60(64'd1 << i) + (64'sd1 <<< 19)) >>> 20);
    pi_q40 = (4 * (atan_inv_q60(2) + atan_inv_q60(3)) + (64'sd1 <<< 19)) >>> 20;

    // order 0
    add_row(0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, ONE, 0, ONE, 0, 0, 0, 1, 0, -102944, 0, 1);
    add_row(0, 0, 0, -ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, -ONE, 0, 0, 0, -ONE, 0, 0, -ONE, 0, 0, 0, 0, 0);
    add_row(0, 131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072,
            0, 0, 0, 0, 0);
    add_row(0, -131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071,
            0, 0, 0, 0, 0);
    add_row(0, 46341, -46341, 65535, 46341, 46341, -65535, 0, 46341, 0, 0, 0, 0, 0);
    add_row(0, 1, -1, -65535, 1, -1, 1, -1, 1, 0, 0, 0, 0, 0);
    add_row(0, -1, 0, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0);
    // order 1
    add_row(1, ONE, 0, 0, 0, ONE, 0, 0, ONE, 1, 0, 0, 0, 0);
    add_row(1, ONE, 0, 0, 0, 0, ONE, 0, 0, 1, 102944, 0, 0, 1);
    add_row(1, -ONE, 0, 0, 0, 0, -ONE, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, 0, -ONE, ONE, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, -ONE, 0, 0, -ONE, 0, 0, 0, 0, 0);
    add_row(1, 131071, 131071, -131072, -131072, 131071, 131071, -131072, 131071,
            0, 0, 0, 0, 0);
    add_row(1, 1, 1, 1, 1, 1, 65535, 1, 1, 0, 0, 0, 0, 0);
    add_row(1, -5, 7, -65535, 3, -9, -65535, 11, -2, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].order != order_cur) drain_and_set(rows[i].order);
      send_matrix(rows[i].m, rows[i].typed, rows[i].res);
    end
    typed_nxt <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_set((ph % 2 == 0) ? 1'b0 : 1'b1);
      for (int n = 0; n < 200; n++) begin
        quiet = (ph == 2 && n >= 50 && n < 150);
        pick = $urandom_range(99);
        if (pick < 60) begin
          d = rand_rotation();
        end else if (pick < 75) begin
          d = rand_rotation();
          s = $urandom_range(1) ? 18'(ONE) : 18'(-ONE);
          if ($urandom_range(1)) d[53:36] = s;
          else d[107:90] = s;
        end else begin
          for (int k = 0; k < 144; k += 16) d[k +: 16] = $urandom();
        end
        send_matrix(d, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (angles_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
